// ===== hdl/joint_trajectory_setpoint_interpolator_core_defines.svh =====
// Assertion macros shared by the trajectory interpolator modules.
`ifndef JOINT_TRAJECTORY_SETPOINT_INTERPOLATOR_CORE_DEFINES_SVH
`define JOINT_TRAJECTORY_SETPOINT_INTERPOLATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define JTSI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jtsi assertion failed");
`define JTSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jtsi assertion failed");
`else
`define JTSI_ASSERT_NOW(label, ante, cons)
`define JTSI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/jtsi_pkg.sv =====
// Types, constants and codes shared by the trajectory interpolator.
package jtsi_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_JOINTS = 16;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int JNT_AW     = $clog2(MAX_JOINTS);
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CW     = $clog2(DIV_STEPS);
  localparam logic [30:0] CAP_ALL_ONES = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_LIMITS = 3'd2,
    OP_START  = 3'd3,
    OP_UPDATE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    RUN_STOPPED = 2'd0,
    RUN_RUNNING = 2'd1,
    RUN_ERROR   = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    MODE_POSITION = 2'd0,
    MODE_VELOCITY = 2'd1,
    MODE_TORQUE   = 2'd2,
    MODE_MIT      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_LERP  = 2'd1,
    KIND_HOLD  = 2'd2,
    KIND_POINT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_SCAN = 3'd1,
    ST_SEL  = 3'd2,
    ST_DIFF = 3'd3,
    ST_MUL  = 3'd4,
    ST_DIV  = 3'd5,
    ST_WB   = 3'd6,
    ST_EMIT = 3'd7
  } ctrl_state_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         joint_num;
    logic [31:0]        time_value;
    logic signed [31:0] position_value;
    logic signed [31:0] velocity_value;
    logic [1:0]         mode_value;
    logic [30:0]        speed_limit;
    logic               last_of_round;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_joint;
    logic [1:0]         command_mode;
    logic signed [31:0] set_position;
    logic signed [31:0] set_velocity;
    logic               trajectory_done;
    logic [1:0]         run_state;
  } out_item_t;

  typedef struct packed {
    logic [3:0]         joint;
    logic [31:0]        ptime;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } point_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic limits;
    logic capture;
    logic scan_init;
    logic scan_issue;
    logic select;
    logic diff;
    logic mul;
    logic div;
    logic wb;
    logic emit;
    logic lane;
    logic done;
    logic [1:0] run_state;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic scan_more;
    logic lerp;
    logic div_last;
    logic stop_hit;
  } dp_status_t;

endpackage

// ===== hdl/jtsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jtsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/jtsi_ctrl.sv =====
// Sequencer for table loads, the point scan and the interpolation steps.
`include "joint_trajectory_setpoint_interpolator_core_defines.svh"
module jtsi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          opcode,
  input  jtsi_pkg::dp_status_t status,
  output jtsi_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import jtsi_pkg::*;

  ctrl_state_t state_r, state_nxt;
  run_t        run_r, run_nxt;
  logic        lane_r, lane_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      run_r   <= RUN_STOPPED;
      lane_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    lane_nxt  = lane_r;
    cmd       = '0;
    cmd.lane  = lane_r;
    cmd.run_state = run_r;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (opcode)
            OP_CLEAR: begin
              cmd.clear = 1'b1;
              run_nxt   = RUN_STOPPED;
            end
            OP_LOAD: begin
              cmd.load = 1'b1;
              if (!status.full) begin
                run_nxt = RUN_STOPPED;
              end
            end
            OP_LIMITS: begin
              cmd.limits = 1'b1;
            end
            OP_START: begin
              run_nxt = status.empty ? RUN_ERROR : RUN_RUNNING;
            end
            OP_UPDATE: begin
              if (run_r == RUN_RUNNING) begin
                cmd.capture   = 1'b1;
                cmd.scan_init = 1'b1;
                lane_nxt      = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (status.scan_more) begin
          cmd.scan_issue = 1'b1;
        end else begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd.select = 1'b1;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        if (status.lerp) begin
          cmd.diff  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        if (lane_r) begin
          state_nxt = ST_EMIT;
        end else begin
          lane_nxt  = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.done = status.stop_hit;
        if (status.stop_hit) begin
          run_nxt       = RUN_STOPPED;
          cmd.run_state = RUN_STOPPED;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `JTSI_ASSERT_NOW(a_emit_running, cmd.emit, run_r == RUN_RUNNING)
  `JTSI_ASSERT_NEXT(a_update_busy, start && !busy && opcode == OP_UPDATE && run_r == RUN_RUNNING, busy)
  `JTSI_ASSERT_NEXT(a_emit_idle, state_r == ST_EMIT, !busy)

endmodule

// ===== hdl/jtsi_dp.sv =====
// Point table, joint limits, scan registers, multiplier and divider.
`include "joint_trajectory_setpoint_interpolator_core_defines.svh"
module jtsi_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  jtsi_pkg::in_item_t    in_item,
  input  jtsi_pkg::dp_cmd_t     cmd,
  output jtsi_pkg::dp_status_t  status,
  output logic                 out_strobe,
  output jtsi_pkg::out_item_t   out_item
);
  import jtsi_pkg::*;

  logic [PT_AW:0]  count_r;
  logic [PT_AW:0]  idx_r;
  logic [31:0]     latest_r;
  logic            rd_v_r;
  logic [1:0]      mode_r [MAX_JOINTS];
  logic [30:0]     cap_r  [MAX_JOINTS];
  in_item_t        req_r;
  point_t          wr_pt, rd_pt;
  logic [$bits(point_t)-1:0] rd_raw;

  logic   any_r, hp_r, hn_r;
  point_t first_r, last_r, prev_r, next_r;

  kind_t              kind_r;
  logic [31:0]        num_r, den_r;
  logic signed [31:0] a_pos_r, b_pos_r, a_vel_r, b_vel_r;
  logic [31:0]        mag_r;
  logic               neg_r;
  logic [32:0]        rem_r;
  logic [31:0]        low_r, quo_r;
  logic [DIV_CW-1:0]  cnt_r;
  logic signed [31:0] res_pos_r, res_vel_r;
  out_item_t          out_r;
  logic               out_v_r;

  assign wr_pt = '{joint: in_item.joint_num, ptime: in_item.time_value,
                   pos: in_item.position_value, vel: in_item.velocity_value};
  assign rd_pt = point_t'(rd_raw);

  jtsi_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (cmd.load && !status.full),
    .waddr (count_r[PT_AW-1:0]),
    .wdata (wr_pt),
    .raddr (idx_r[PT_AW-1:0]),
    .rdata (rd_raw)
  );

  assign status.empty     = (count_r == '0);
  assign status.full      = (count_r == (PT_AW+1)'(MAX_POINTS));
  assign status.scan_more = (idx_r < count_r);
  assign status.lerp      = (kind_r == KIND_LERP);
  assign status.div_last  = (cnt_r == DIV_CW'(DIV_STEPS - 1));
  assign status.stop_hit  = req_r.last_of_round && (req_r.time_value >= latest_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      latest_r <= '0;
      rd_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      for (int j = 0; j < MAX_JOINTS; j++) begin
        mode_r[j] <= MODE_POSITION;
        cap_r[j]  <= CAP_ALL_ONES;
      end
    end else begin
      rd_v_r  <= cmd.scan_issue;
      out_v_r <= cmd.emit;
      if (cmd.clear) begin
        count_r  <= '0;
        latest_r <= '0;
      end
      if (cmd.load && !status.full) begin
        count_r <= count_r + 1'b1;
        if (in_item.time_value > latest_r) begin
          latest_r <= in_item.time_value;
        end
      end
      if (cmd.limits && (32'(in_item.joint_num) < MAX_JOINTS)) begin
        mode_r[in_item.joint_num[JNT_AW-1:0]] <= in_item.mode_value;
        cap_r[in_item.joint_num[JNT_AW-1:0]]  <= in_item.speed_limit;
      end
    end
  end

  // Scan: keep the first, last, previous and next points of the joint.
  logic       match;
  logic [31:0] t_q;
  assign t_q   = req_r.time_value;
  assign match = rd_v_r && (rd_pt.joint == req_r.joint_num);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_item;
    end
    if (cmd.scan_init) begin
      idx_r <= '0;
      any_r <= 1'b0;
      hp_r  <= 1'b0;
      hn_r  <= 1'b0;
    end
    if (cmd.scan_issue) begin
      idx_r <= idx_r + 1'b1;
    end
    if (match) begin
      any_r <= 1'b1;
      if (!any_r || rd_pt.ptime < first_r.ptime) begin
        first_r <= rd_pt;
      end
      if (!any_r || rd_pt.ptime >= last_r.ptime) begin
        last_r <= rd_pt;
      end
      if (rd_pt.ptime <= t_q && (!hp_r || rd_pt.ptime > prev_r.ptime)) begin
        prev_r <= rd_pt;
        hp_r   <= 1'b1;
      end
      if (rd_pt.ptime >= t_q && (!hn_r || rd_pt.ptime < next_r.ptime)) begin
        next_r <= rd_pt;
        hn_r   <= 1'b1;
      end
    end
  end

  // Segment selection
  point_t p0, p1;
  assign p0 = hp_r ? prev_r : first_r;
  assign p1 = hn_r ? next_r : last_r;

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      num_r   <= t_q - p0.ptime;
      den_r   <= p1.ptime - p0.ptime;
      a_pos_r <= p0.pos;
      b_pos_r <= p1.pos;
      a_vel_r <= p0.vel;
      b_vel_r <= p1.vel;
      if (!any_r) begin
        kind_r <= KIND_NONE;
      end else if (p1.ptime != p0.ptime && t_q >= p0.ptime && t_q <= p1.ptime) begin
        kind_r <= KIND_LERP;
      end else if (t_q > p1.ptime) begin
        kind_r <= KIND_HOLD;
      end else begin
        kind_r <= KIND_POINT;
      end
    end
  end

  // Interpolation: |b - a| * num / den, then a +/- quotient.
  logic signed [31:0] a_l, b_l;
  logic [32:0]        d_l;
  logic [63:0]        prod;
  logic [32:0]        r2;
  logic               qbit;
  assign a_l  = cmd.lane ? a_vel_r : a_pos_r;
  assign b_l  = cmd.lane ? b_vel_r : b_pos_r;
  assign d_l  = {b_l[31], b_l} - {a_l[31], a_l};
  assign prod = {32'd0, mag_r} * {32'd0, num_r};
  assign r2   = {rem_r[31:0], low_r[31]};
  assign qbit = (r2 >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      neg_r <= d_l[32];
      mag_r <= d_l[32] ? 32'(-d_l) : d_l[31:0];
    end
    if (cmd.mul) begin
      rem_r <= {1'b0, prod[63:32]};
      low_r <= prod[31:0];
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div) begin
      rem_r <= qbit ? (r2 - {1'b0, den_r}) : r2;
      low_r <= {low_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], qbit};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.wb) begin
      if (cmd.lane) begin
        res_vel_r <= neg_r ? a_vel_r - $signed(quo_r) : a_vel_r + $signed(quo_r);
      end else begin
        res_pos_r <= neg_r ? a_pos_r - $signed(quo_r) : a_pos_r + $signed(quo_r);
      end
    end
  end

  // Command assembly
  logic signed [31:0] dpos, dvel, cvel;
  logic [1:0]         jmode;
  logic [30:0]        jcap;
  logic signed [32:0] v33, cap33;

  always_comb begin
    case (kind_r)
      KIND_LERP: begin
        dpos = res_pos_r;
        dvel = res_vel_r;
      end
      KIND_HOLD: begin
        dpos = b_pos_r;
        dvel = '0;
      end
      KIND_POINT: begin
        dpos = a_pos_r;
        dvel = a_vel_r;
      end
      default: begin
        dpos = req_r.position_value;
        dvel = '0;
      end
    endcase
    if (32'(req_r.joint_num) < MAX_JOINTS) begin
      jmode = mode_r[req_r.joint_num[JNT_AW-1:0]];
      jcap  = cap_r[req_r.joint_num[JNT_AW-1:0]];
    end else begin
      jmode = MODE_POSITION;
      jcap  = CAP_ALL_ONES;
    end
    v33   = {dvel[31], dvel};
    cap33 = {2'b00, jcap};
    if (v33 > cap33) begin
      cvel = 32'(cap33);
    end else if (v33 < -cap33) begin
      cvel = 32'(-cap33);
    end else begin
      cvel = dvel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.out_joint       <= req_r.joint_num;
      out_r.command_mode    <= jmode;
      out_r.trajectory_done <= cmd.done;
      out_r.run_state       <= cmd.run_state;
      case (jmode)
        MODE_VELOCITY: begin
          out_r.set_position <= '0;
          out_r.set_velocity <= cvel;
        end
        MODE_TORQUE: begin
          out_r.set_position <= '0;
          out_r.set_velocity <= '0;
        end
        MODE_MIT: begin
          out_r.set_position <= dpos;
          out_r.set_velocity <= cvel;
        end
        default: begin
          out_r.set_position <= dpos;
          out_r.set_velocity <= '0;
        end
      endcase
    end
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

  `JTSI_ASSERT_NOW(a_div_rem, cmd.div, !rem_r[32] && (rem_r[31:0] < den_r))
  `JTSI_ASSERT_NOW(a_count_max, 1'b1, count_r <= (PT_AW+1)'(MAX_POINTS))
  `JTSI_ASSERT_NEXT(a_strobe_emit, cmd.emit, out_strobe)

endmodule

// ===== hdl/joint_trajectory_setpoint_interpolator_core.sv =====
// Clear, load, limit load and start finish at the accepting edge; busy stays low. An update
// while running scans all N stored points and, when it interpolates, runs the diff, multiply,
// divide and write-back steps for position, then velocity, and emits; busy stays high
// throughout and the result strobes as busy falls. Throughput: one transaction at a time; a
// 32x32 multiplier and a 32-step divider serve both lanes. Reset (rst_n low, synchronous)
// empties the table, stops the controller and clears joint limits; the receiver cannot stall.
module joint_trajectory_setpoint_interpolator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  jtsi_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output jtsi_pkg::out_item_t  out_item
);
  import jtsi_pkg::*;

  // The controller owns the run state and the step sequence; the datapath owns all other storage.
  dp_cmd_t    cmd;
  dp_status_t status;

  // A transaction is taken while busy is low; only an update that finds the controller
  // running raises busy, and its result shows for one cycle on out_strobe.
  jtsi_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_item.opcode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the point table in RAM, the joint limits in flip-flops and the
  // interpolation arithmetic between them.
  jtsi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== tb/joint_trajectory_setpoint_interpolator_core_test.sv =====
// Self-checking testbench for the trajectory setpoint interpolator core.
`timescale 1ns / 100ps

module joint_trajectory_setpoint_interpolator_core_test;
  import jtsi_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  joint_trajectory_setpoint_interpolator_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block's state, kept by the command predictor.
  point_t      tbl [MAX_POINTS];
  int unsigned tbl_count;
  logic [1:0]  mode_of [MAX_JOINTS];
  logic [30:0] cap_of [MAX_JOINTS];
  logic [31:0] latest_time;
  run_t        run_now;

  in_item_t  pending_items [$];
  out_item_t awaited_cmds [$];
  int        error_count;
  int        cmd_count;
  bit        hold_for_drain;

  // Append one transaction to the pending list.
  task automatic enqueue(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Linear step from a to b by num/den, magnitude truncated toward zero.
  function automatic logic signed [31:0] lerp_step(logic signed [31:0] a,
      logic signed [31:0] b, logic [31:0] num, logic [31:0] den);
    logic signed [63:0] d;
    logic [63:0]        m;
    logic [63:0]        q;
    d = 64'(b) - 64'(a);
    m = d[63] ? 64'(-d) : 64'(d);
    q = (m * 64'(num)) / 64'(den);
    return d[63] ? 32'(64'(a) - q) : 32'(64'(a) + q);
  endfunction

  // Apply one transaction to the shadow state; queue a command if one results.
  task automatic predict_command(in_item_t it);
    int          ip, inx, ifirst, ilast;
    bit          hp, hn, any;
    logic [31:0] t, t0, t1, pt;
    logic signed [31:0] dpos, dvel;
    logic signed [32:0] v, capv;
    logic [1:0]  md;
    logic [30:0] cap;
    out_item_t   o;
    case (it.opcode)
      OP_CLEAR: begin
        tbl_count = 0; latest_time = '0; run_now = RUN_STOPPED;
      end
      OP_LOAD: begin
        if (tbl_count < MAX_POINTS) begin
          tbl[tbl_count] = '{it.joint_num, it.time_value, it.position_value,
                             it.velocity_value};
          tbl_count++;
          if (it.time_value > latest_time) latest_time = it.time_value;
          run_now = RUN_STOPPED;
        end
      end
      OP_LIMITS: begin
        mode_of[it.joint_num] = it.mode_value;
        cap_of[it.joint_num]  = it.speed_limit;
      end
      OP_START: run_now = (tbl_count == 0) ? RUN_ERROR : RUN_RUNNING;
      OP_UPDATE: begin
        if (run_now == RUN_RUNNING) begin
          t = it.time_value;
          ip = 0; inx = 0; ifirst = 0; ilast = 0; hp = 0; hn = 0; any = 0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl[i].joint == it.joint_num) begin
              pt = tbl[i].ptime;
              if (!any || pt < tbl[ifirst].ptime) ifirst = i;
              if (!any || pt >= tbl[ilast].ptime) ilast = i;
              any = 1;
              if (pt <= t && (!hp || pt > tbl[ip].ptime)) begin ip = i; hp = 1; end
              if (pt >= t && (!hn || pt < tbl[inx].ptime)) begin inx = i; hn = 1; end
            end
          end
          if (!any) begin
            dpos = it.position_value; dvel = '0;
          end else begin
            if (!hp) ip = ifirst;
            if (!hn) inx = ilast;
            t0 = tbl[ip].ptime; t1 = tbl[inx].ptime;
            if (t1 != t0 && t >= t0 && t <= t1) begin
              dpos = lerp_step(tbl[ip].pos, tbl[inx].pos, t - t0, t1 - t0);
              dvel = lerp_step(tbl[ip].vel, tbl[inx].vel, t - t0, t1 - t0);
            end else if (t > t1) begin
              dpos = tbl[inx].pos; dvel = '0;
            end else begin
              dpos = tbl[ip].pos; dvel = tbl[ip].vel;
            end
          end
          md = mode_of[it.joint_num]; cap = cap_of[it.joint_num];
          v = 33'(dvel); capv = {2'b00, cap};
          if (v > capv) v = capv;
          if (v < -capv) v = -capv;
          dvel = v[31:0];
          o.out_joint = it.joint_num;
          o.command_mode = md;
          case (md)
            MODE_VELOCITY: begin o.set_position = '0; o.set_velocity = dvel; end
            MODE_TORQUE:   begin o.set_position = '0; o.set_velocity = '0; end
            MODE_MIT:      begin o.set_position = dpos; o.set_velocity = dvel; end
            default:       begin o.set_position = dpos; o.set_velocity = '0; end
          endcase
          o.trajectory_done = 1'b0;
          if (it.last_of_round && t >= latest_time) begin
            run_now = RUN_STOPPED; o.trajectory_done = 1'b1;
          end
          o.run_state = run_now;
          awaited_cmds.insert(awaited_cmds.size(), o);
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(logic [2:0] op, int j, logic [31:0] t,
      logic [31:0] p, logic [31:0] v, bit last);
    in_item_t it;
    it.opcode = op; it.joint_num = 4'(j); it.time_value = t;
    it.position_value = p; it.velocity_value = v;
    it.mode_value = 2'($urandom); it.speed_limit = 31'($urandom >> 1);
    it.last_of_round = last;
    return it;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000 ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
      1: return $urandom_range(0, 8) << 16;
      default: return $urandom;
    endcase
  endfunction

  // Driver: bursts with random gaps; a drain pause holds off until all commands arrive.
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0; in_item <= '0; burst_left <= 0; gap_left <= 0;
    end else if (start && !busy) begin
      // The held transaction was accepted at this edge.
      predict_command(in_item);
      void'(pending_items.pop_front());
      if (pending_items.size() != 0 && burst_left > 0 && !hold_for_drain) begin
        in_item <= pending_items[0]; burst_left <= burst_left - 1;
      end else begin
        start <= 1'b0; gap_left <= $urandom_range(0, 6);
      end
    end else if (!start) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_items.size() != 0 &&
               !(hold_for_drain && awaited_cmds.size() != 0)) begin
        start <= 1'b1; in_item <= pending_items[0];
        burst_left <= $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(5, 30);
      end
    end
  end

  // Monitor: every strobe carries one command, checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_strobe) begin
      cmd_count++;
      if (awaited_cmds.size() == 0) begin
        $error("unexpected command for joint %0d", out_item.out_joint);
        error_count++;
      end else begin
        e = awaited_cmds.pop_front();
        if (out_item.out_joint !== e.out_joint) begin
          $error("out_joint: expected %0d, got %0d", e.out_joint, out_item.out_joint);
          error_count++;
        end
        if (out_item.command_mode !== e.command_mode) begin
          $error("command_mode: expected %0d, got %0d", e.command_mode,
                 out_item.command_mode);
          error_count++;
        end
        if (out_item.set_position !== e.set_position) begin
          $error("set_position: expected %h, got %h", e.set_position,
                 out_item.set_position);
          error_count++;
        end
        if (out_item.set_velocity !== e.set_velocity) begin
          $error("set_velocity: expected %h, got %h", e.set_velocity,
                 out_item.set_velocity);
          error_count++;
        end
        if (out_item.trajectory_done !== e.trajectory_done) begin
          $error("trajectory_done: expected %0d, got %0d", e.trajectory_done,
                 out_item.trajectory_done);
          error_count++;
        end
        if (out_item.run_state !== e.run_state) begin
          $error("run_state: expected %0d, got %0d", e.run_state, out_item.run_state);
          error_count++;
        end
      end
    end
  end

  // Queue a limit load with a chosen mode and cap.
  task automatic add_limits(int j, logic [1:0] md, logic [30:0] cap);
    in_item_t it;
    it = make_item(OP_LIMITS, j, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    it.mode_value = md; it.speed_limit = cap;
    enqueue(it);
  endtask

  // One well-formed trajectory: clear, limits, points for a few joints, start,
  // then rounds of updates at random times.
  task automatic add_trajectory();
    int nj, np, nr, base;
    logic [31:0] tmax;
    nj = $urandom_range(1, 4);
    base = $urandom_range(0, 12);
    tmax = 0;
    enqueue(make_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, 0));
    for (int j = 0; j < nj; j++)
      add_limits(base + j, 2'($urandom), $urandom_range(0, 3) == 0 ? CAP_ALL_ONES :
                 31'($urandom_range(0, 5) << 16));
    np = $urandom_range(0, 9) == 0 ? $urandom_range(40, 66) : $urandom_range(1, 8);
    for (int k = 0; k < np; k++) begin
      logic [31:0] pt;
      pt = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 200);
      if (pt > tmax && pt < 32'h1000) tmax = pt;
      enqueue(make_item(OP_LOAD, base + $urandom_range(0, nj), pt,
                        rand_word(), rand_word(), 0));
    end
    enqueue(make_item(OP_START, $urandom, $urandom, $urandom, $urandom, 0));
    nr = $urandom_range(1, 4);
    for (int r = 0; r < nr; r++) begin
      logic [31:0] t;
      t = (r == nr - 1 && $urandom_range(0, 1)) ? tmax + $urandom_range(0, 20)
                                                 : $urandom_range(0, 220);
      for (int j = 0; j < nj; j++)
        enqueue(make_item(OP_UPDATE, base + j, t, rand_word(), $urandom, j == nj - 1));
    end
  endtask

  initial begin
    in_item_t it;
    rst_n = 1'b0;
    error_count = 0; cmd_count = 0; hold_for_drain = 0;
    tbl_count = 0; latest_time = '0; run_now = RUN_STOPPED;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      mode_of[j] = MODE_POSITION; cap_of[j] = CAP_ALL_ONES;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: update while stopped, start on an empty table, joint with no
    // points, extremes of position, equal times, before-first and past-last.
    enqueue(make_item(OP_UPDATE, 0, 0, 0, 0, 1));
    enqueue(make_item(OP_START, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 1, 5, 0, 0, 0));
    add_limits(0, MODE_MIT, CAP_ALL_ONES);
    add_limits(1, MODE_VELOCITY, 31'h0001_0000);
    add_limits(2, MODE_TORQUE, 31'h0);
    enqueue(make_item(OP_LOAD, 0, 10, 32'h8000_0000, 32'h7FFF_FFFF, 0));
    enqueue(make_item(OP_LOAD, 0, 20, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    enqueue(make_item(OP_LOAD, 0, 20, 32'h0001_0000, 32'h0, 0));
    enqueue(make_item(OP_LOAD, 1, 32'hFFFF_FFFF, 32'h0003_0000, 32'hFFF0_0000, 0));
    enqueue(make_item(OP_LOAD, 1, 0, 32'h0, 32'h0010_0000, 0));
    enqueue(make_item(OP_START, 0, 0, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 0, 5, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 0, 15, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 0, 20, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 0, 25, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 1, 32'h8000_0000, 0, 0, 0));
    enqueue(make_item(OP_UPDATE, 2, 3, 32'h1234_5678, 0, 0));
    enqueue(make_item(OP_UPDATE, 15, 3, 32'h8000_0000, 0, 0));
    it = make_item(3'd7, 0, 0, 0, 0, 0);
    enqueue(it);
    enqueue(make_item(OP_UPDATE, 0, 32'hFFFF_FFFF, 0, 0, 1));
    enqueue(make_item(OP_UPDATE, 0, 15, 0, 0, 0));
    add_limits(15, MODE_POSITION, CAP_ALL_ONES);

    // Wait for the directed commands, then pause the sender once more mid-run.
    wait (pending_items.size() == 0 && awaited_cmds.size() == 0);
    repeat (200) @(posedge clk);
    while (pending_items.size() < 1250) begin
      if ($urandom_range(0, 9) == 0) begin
        it.opcode = 3'($urandom); it.joint_num = 4'($urandom); it.time_value = $urandom;
        it.position_value = $urandom; it.velocity_value = $urandom;
        it.mode_value = 2'($urandom); it.speed_limit = 31'($urandom);
        it.last_of_round = 1'($urandom);
        // Noise never reads table entries that were not written.
        if (it.opcode == OP_LOAD || it.opcode == OP_UPDATE) it.opcode = OP_START;
        if (it.opcode == OP_START && tbl_count == 0) it.opcode = OP_LIMITS;
        enqueue(it);
      end else add_trajectory();
    end
    // Each transaction now waits until all earlier commands have arrived.
    hold_for_drain = 1;
    wait (pending_items.size() < 500);
    hold_for_drain = 0;
    wait (pending_items.size() == 0 && !start);
    wait (awaited_cmds.size() == 0);
    repeat (300) @(posedge clk);
    $display("Covered %0d commands across clears, loads, limits, starts and updates,",
             cmd_count);
    $display("including table overflow, empty-table start and hold past the last point.");
    if (error_count == 0 && awaited_cmds.size() == 0)
      $display("joint_trajectory_setpoint_interpolator_core_test: done, clean");
    else
      $display("joint_trajectory_setpoint_interpolator_core_test: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("joint_trajectory_setpoint_interpolator_core_test: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/jtsi_pkg.sv
hdl/jtsi_ram.sv
hdl/jtsi_ctrl.sv
hdl/jtsi_dp.sv
hdl/joint_trajectory_setpoint_interpolator_core.sv
tb/joint_trajectory_setpoint_interpolator_core_test.sv
